// ----- rtl/kpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the key press classifier.
// Used by every module under rtl; depends on nothing.
package kpc_pkg;

  localparam int TimerWidthDefault = 16;
  localparam int LimitWidth        = 14;
  localparam int StepWidth         = 8;
  localparam int CfgIndexWidth     = 3;
  localparam int CfgDataWidth      = LimitWidth;

  // register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] CFG_LONG_ENABLE   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DOUBLE_ENABLE = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_TICK_STEP     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_LONG_LIMIT    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_SHORT_LIMIT   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_DOUBLE_WINDOW = 3'd5;

  // values after reset
  localparam logic                  RST_LONG_ENABLE   = 1'b1;
  localparam logic                  RST_DOUBLE_ENABLE = 1'b0;
  localparam logic [StepWidth-1:0]  RST_TICK_STEP     = 8'd20;
  localparam logic [LimitWidth-1:0] RST_LONG_LIMIT    = 14'd1000;
  localparam logic [LimitWidth-1:0] RST_SHORT_LIMIT   = 14'd200;
  localparam logic [LimitWidth-1:0] RST_DOUBLE_WINDOW = 14'd200;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } key_event_t;

  typedef struct packed {
    logic                  long_enable;
    logic                  double_enable;
    logic [StepWidth-1:0]  tick_step;
    logic [LimitWidth-1:0] long_limit;
    logic [LimitWidth-1:0] short_limit;
    logic [LimitWidth-1:0] double_window;
  } cfg_t;

endpackage

// ----- rtl/kpc_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register bank for the key press classifier.
// Depends on kpc_pkg for register indexes, reset values and cfg_t.
module kpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [kpc_pkg::CfgDataWidth-1:0]  cfg_data,
  output kpc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_enable   <= kpc_pkg::RST_LONG_ENABLE;
      cfg.double_enable <= kpc_pkg::RST_DOUBLE_ENABLE;
      cfg.tick_step     <= kpc_pkg::RST_TICK_STEP;
      cfg.long_limit    <= kpc_pkg::RST_LONG_LIMIT;
      cfg.short_limit   <= kpc_pkg::RST_SHORT_LIMIT;
      cfg.double_window <= kpc_pkg::RST_DOUBLE_WINDOW;
    end else if (cfg_write) begin
      case (cfg_index)
        kpc_pkg::CFG_LONG_ENABLE:   cfg.long_enable   <= cfg_data[0];
        kpc_pkg::CFG_DOUBLE_ENABLE: cfg.double_enable <= cfg_data[0];
        kpc_pkg::CFG_TICK_STEP:     cfg.tick_step     <= cfg_data[kpc_pkg::StepWidth-1:0];
        kpc_pkg::CFG_LONG_LIMIT:    cfg.long_limit    <= cfg_data;
        kpc_pkg::CFG_SHORT_LIMIT:   cfg.short_limit   <= cfg_data;
        kpc_pkg::CFG_DOUBLE_WINDOW: cfg.double_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/kpc_core.sv -----
`timescale 1ns / 1ps
// Key state, press and gap timers, and the per-tick event decision.
// Depends on kpc_pkg for cfg_t and the event codes.
module kpc_core #(
  parameter int TIMER_WIDTH = kpc_pkg::TimerWidthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  kpc_pkg::cfg_t       cfg,
  input  logic                step,
  input  logic                pin_level,
  output kpc_pkg::key_event_t event_code
);

  // wide enough for timer + step and for short_limit + 1 without wrapping
  localparam int W = ((TIMER_WIDTH > kpc_pkg::LimitWidth) ? TIMER_WIDTH
                                                          : kpc_pkg::LimitWidth) + 1;
  localparam logic [W-1:0] TMAX = W'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic                   level_now;
  logic [TIMER_WIDTH-1:0] press_time;
  logic [TIMER_WIDTH-1:0] gap_time;
  logic                   first_seen;

  logic                   level_now_next;
  logic [TIMER_WIDTH-1:0] press_time_next;
  logic [TIMER_WIDTH-1:0] gap_time_next;
  logic                   first_seen_next;

  function automatic logic [W-1:0] sat(input logic [W-1:0] v);
    sat = (v > TMAX) ? TMAX : v;
  endfunction

  always_comb begin
    logic         lb;
    logic         ln;
    logic [W-1:0] p;
    logic [W-1:0] g;
    logic [W-1:0] step_w;
    logic [W-1:0] ll;
    logic [W-1:0] sl;
    logic [W-1:0] dw;
    logic         fs;
    kpc_pkg::key_event_t ev;

    lb     = level_now;
    ln     = ~pin_level;
    p      = W'(press_time);
    g      = W'(gap_time);
    fs     = first_seen;
    step_w = W'(cfg.tick_step);
    ll     = W'(cfg.long_limit);
    sl     = W'(cfg.short_limit);
    dw     = W'(cfg.double_window);
    ev     = kpc_pkg::EV_NONE;

    // press start
    if (!lb && ln && cfg.long_enable) begin
      p = '0;
    end
    // hold
    if (lb && ln && cfg.long_enable && (p <= ll)) begin
      p = sat(p + step_w);
    end
    // long press, reload so it repeats and the release is not short
    if (lb && cfg.long_enable && (p > ll)) begin
      ev = kpc_pkg::EV_LONG;
      p  = sat(sl + W'(1));
    end
    // release
    if (lb && !ln && (p <= sl)) begin
      if (!cfg.double_enable) begin
        ev = kpc_pkg::EV_SHORT;
      end else if (!fs) begin
        fs = 1'b1;
        g  = '0;
      end else if (g <= dw) begin
        ev = kpc_pkg::EV_DOUBLE;
        fs = 1'b0;
      end
    end
    // gap window runs, expiry reports the first press as short
    if (fs) begin
      g = sat(g + step_w);
      if (g > dw) begin
        ev = kpc_pkg::EV_SHORT;
        fs = 1'b0;
      end
    end

    level_now_next  = ln;
    press_time_next = p[TIMER_WIDTH-1:0];
    gap_time_next   = g[TIMER_WIDTH-1:0];
    first_seen_next = fs;
    event_code      = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now  <= 1'b0;
      press_time <= '0;
      gap_time   <= '0;
      first_seen <= 1'b0;
    end else if (step) begin
      level_now  <= level_now_next;
      press_time <= press_time_next;
      gap_time   <= gap_time_next;
      first_seen <= first_seen_next;
    end
  end

endmodule

// ----- rtl/kpc_out_buf.sv -----
`timescale 1ns / 1ps
// Two-word result buffer between the classifier and the output channel.
// Depends on kpc_pkg for the event code type.
module kpc_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kpc_pkg::key_event_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          key_event
);

  kpc_pkg::key_event_t head;
  kpc_pkg::key_event_t tail;
  logic [1:0]          count;
  logic                pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign key_event = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11: count <= count;
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload: advance the tail into the head on a pop, land new words behind
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head <= tail;
          tail <= push_data;
        end
      end
      2'b10: begin
        if (count == 2'd0) begin
          head <= push_data;
        end else begin
          tail <= push_data;
        end
      end
      2'b01: head <= tail;
      default: ;
    endcase
  end

endmodule

// ----- rtl/key_press_classifier.sv -----
`timescale 1ns / 1ps
// Top level of the key press classifier: config bank, classifier, result buffer.
// Depends on kpc_pkg, kpc_cfg_regs, kpc_core and kpc_out_buf.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  in      | in_valid  | in_stall  | pin_level
//  out     | out_valid | out_stall | key_event
//  cfg     | cfg_write | -         | cfg_index, cfg_data
//
// One sampled level is taken per cycle while in_stall is low; its event word is registered in the result buffer.
// The timer update and event choice are combinational compares and adds.
// Reset (rst, synchronous) restores register defaults and clears key state.
// A two-word buffer lets the input keep flowing during an output stall while a word is free;
// in_stall rises only when both buffer words are held.
module key_press_classifier #(
  parameter int TIMER_WIDTH = kpc_pkg::TimerWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        key_event,
  input  logic                              cfg_write,
  input  logic [kpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [kpc_pkg::CfgDataWidth-1:0]  cfg_data
);

  kpc_pkg::cfg_t       cfg;
  kpc_pkg::key_event_t event_code;
  logic                step;
  logic                full;

  assign in_stall = full;
  assign step     = in_valid && !full;

  kpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .pin_level  (pin_level),
    .event_code (event_code)
  );

  kpc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (event_code),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_event (key_event)
  );

endmodule
